@@ hw/rtl/ciau_pkg.sv @@
package ciau_pkg;

  localparam logic [2:0] KIND_SEC   = 3'd0;
  localparam logic [2:0] KIND_MIN   = 3'd1;
  localparam logic [2:0] KIND_HOUR  = 3'd2;
  localparam logic [2:0] KIND_DAY   = 3'd3;
  localparam logic [2:0] KIND_MONTH = 3'd4;
  localparam logic [2:0] KIND_YEAR  = 3'd5;

  localparam logic [6:0] DIV_BY_60  = 7'd60;
  localparam logic [6:0] DIV_BY_24  = 7'd24;
  localparam logic [6:0] DIV_BY_12  = 7'd12;
  localparam logic [6:0] DIV_BY_100 = 7'd100;
  localparam logic [6:0] DIV_BY_7   = 7'd7;

  // reciprocals ceil(2^24 / d); quotient = (x * recip) >> 24, exact for 17-bit x
  localparam logic [21:0] RECIP_60  = 22'd279621;
  localparam logic [21:0] RECIP_24  = 22'd699051;
  localparam logic [21:0] RECIP_12  = 22'd1398102;
  localparam logic [21:0] RECIP_100 = 22'd167773;
  localparam logic [21:0] RECIP_7   = 22'd2396746;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] amount;
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [2:0]  in_weekday;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [9:0]  in_millis;
  } in_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  out_weekday;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [9:0]  out_millis;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_SEC,
    OP_DIV_MIN,
    OP_DIV_HOUR,
    OP_DIV_MON,
    OP_DIV_YEAR,
    OP_DIV_ZEL,
    OP_DIV_F,
    OP_WR_SEC,
    OP_WR_MIN,
    OP_WR_HOUR,
    OP_WR_MON,
    OP_WR_KJ,
    OP_DAY_STEP,
    OP_YEAR_ADD,
    OP_FIX,
    OP_WR_ZKJ,
    OP_WR_WDAY,
    OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEC_D,
    S_SEC_W,
    S_MIN_D,
    S_MIN_W,
    S_HOUR_D,
    S_HOUR_W,
    S_DKJ_D,
    S_DKJ_W,
    S_DAY_LOOP,
    S_MON_D,
    S_MON_W,
    S_LEAP_D,
    S_LEAP_W,
    S_FIX,
    S_ZEL_D,
    S_ZEL_W,
    S_F_D,
    S_F_W,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       div_busy;
    logic       quot_zero;
    logic       n_zero;
    logic       t_zero;
  } ctrl_sts_t;

endpackage

@@ hw/rtl/ciau_datapath.sv @@
module ciau_datapath
  import ciau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  input  in_t       in_data,
  output out_t      out_data
);

  logic [2:0]  kind;
  logic [16:0] carry;
  logic [15:0] n;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  millis;
  logic [6:0]  k;
  logic [9:0]  j;
  logic [6:0]  zk;
  logic [9:0]  zj;

  // shared constant divider: quotient by reciprocal multiply, then remainder
  logic [16:0] quot;
  logic [6:0]  rem;
  logic [16:0] dvdnd;
  logic [6:0]  dvsr;
  logic [21:0] recip;
  logic [1:0]  cnt;
  logic        div_start;
  logic [16:0] div_in;
  logic [6:0]  div_by;
  logic [21:0] div_recip;
  logic [38:0] prod;
  logic [16:0] q_d;
  logic [16:0] r_full;

  logic        lp;
  logic [4:0]  len;
  logic [4:0]  left;
  logic [16:0] t_mon;
  logic [4:0]  m1;
  logic [4:0]  zm;
  logic [8:0]  x13;
  logic [16:0] x205;
  logic [12:0] f;
  logic [3:0]  w5;

  // leap: y%4==0 and y%100!=0, or y%400==0, from k = y%100 and j = y/100
  assign lp = ((year[1:0] == 2'd0) && (k != 7'd0)) || ((k == 7'd0) && (j[1:0] == 2'd0));

  always_comb begin
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = lp ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
  end

  assign left  = (day <= len) ? (len - day) : 5'd0;
  assign t_mon = {13'd0, month} + carry;
  assign m1    = {1'b0, month} + 5'd1;

  // Zeller terms
  assign zm   = (month < 4'd3) ? ({1'b0, month} + 5'd12) : {1'b0, month};
  assign x13  = 9'(13 * ({4'd0, zm} + 9'd1));
  assign x205 = {8'd0, x13} * 17'd205;
  assign f    = {8'd0, day} + {6'd0, x205[16:10]} + {6'd0, zk} + {8'd0, zk[6:2]}
              + {5'd0, zj[9:2]} + 13'({zj, 2'b00} + {2'd0, zj});
  assign w5   = {1'b0, rem[2:0]} + 4'd5;

  always_comb begin
    div_start = 1'b1;
    div_in    = 17'd0;
    div_by    = DIV_BY_7;
    div_recip = RECIP_7;
    case (cmd.op)
      OP_DIV_SEC: begin
        div_in = {11'd0, second} + carry; div_by = DIV_BY_60; div_recip = RECIP_60;
      end
      OP_DIV_MIN: begin
        div_in = {11'd0, minute} + carry; div_by = DIV_BY_60; div_recip = RECIP_60;
      end
      OP_DIV_HOUR: begin
        div_in = {12'd0, hour} + carry; div_by = DIV_BY_24; div_recip = RECIP_24;
      end
      OP_DIV_MON: begin
        div_in = t_mon - 17'd1; div_by = DIV_BY_12; div_recip = RECIP_12;
      end
      OP_DIV_YEAR: begin
        div_in = {1'b0, year}; div_by = DIV_BY_100; div_recip = RECIP_100;
      end
      OP_DIV_ZEL: begin
        div_in    = {1'b0, (month < 4'd3) ? (year - 16'd1) : year};
        div_by    = DIV_BY_100;
        div_recip = RECIP_100;
      end
      OP_DIV_F: begin
        div_in = {4'd0, f}; div_by = DIV_BY_7; div_recip = RECIP_7;
      end
      default: div_start = 1'b0;
    endcase
  end

  // quotient fits 15 bits since the smallest divisor is 7
  assign prod   = {22'd0, dvdnd} * {17'd0, recip};
  assign q_d    = quot * {10'd0, dvsr};
  assign r_full = dvdnd - q_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (div_start) begin
      cnt <= 2'd2;
    end else if (cnt != 2'd0) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dvdnd <= div_in;
      dvsr  <= div_by;
      recip <= div_recip;
    end else if (cnt == 2'd2) begin
      quot <= {2'd0, prod[38:24]};
    end else if (cnt == 2'd1) begin
      rem <= r_full[6:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind    <= in_data.kind;
        carry   <= {1'b0, in_data.amount};
        n       <= in_data.amount;
        year    <= in_data.in_year;
        month   <= in_data.in_month;
        day     <= in_data.in_day;
        weekday <= in_data.in_weekday;
        hour    <= in_data.in_hour;
        minute  <= in_data.in_minute;
        second  <= in_data.in_second;
        millis  <= in_data.in_millis;
      end
      OP_WR_SEC: begin
        second <= rem[5:0];
        carry  <= quot;
      end
      OP_WR_MIN: begin
        minute <= rem[5:0];
        carry  <= quot;
      end
      OP_WR_HOUR: begin
        hour <= rem[4:0];
        n    <= quot[15:0];
      end
      OP_WR_MON: begin
        year  <= year + quot[15:0];
        month <= rem[3:0] + 4'd1;
      end
      OP_WR_KJ: begin
        k <= rem;
        j <= quot[9:0];
      end
      OP_DAY_STEP: begin
        if (n <= {11'd0, left}) begin
          day <= day + n[4:0];
          n   <= 16'd0;
        end else begin
          n   <= n - ({11'd0, left} + 16'd1);
          day <= 5'd1;
          if (m1 > 5'd12) begin
            month <= 4'd1;
            year  <= year + 16'd1;
            // keep year%100 and year/100 in step, including the wrap to zero
            if (year == 16'hFFFF) begin
              k <= 7'd0;
              j <= 10'd0;
            end else if (k == 7'd99) begin
              k <= 7'd0;
              j <= j + 10'd1;
            end else begin
              k <= k + 7'd1;
            end
          end else begin
            month <= m1[3:0];
          end
        end
      end
      OP_YEAR_ADD: year <= year + carry[15:0];
      OP_FIX: begin
        if (kind == KIND_MONTH) begin
          if (day > len) day <= len;
        end else begin
          if ((month == 4'd2) && (day == 5'd29) && !lp) day <= 5'd28;
        end
      end
      OP_WR_ZKJ: begin
        zk <= rem;
        zj <= quot[9:0];
      end
      OP_WR_WDAY: weekday <= ((w5 >= 4'd7) ? 3'(w5 - 4'd7) : w5[2:0]) + 3'd1;
      OP_FINISH: begin
        out_data.out_year    <= year;
        out_data.out_month   <= month;
        out_data.out_day     <= day;
        out_data.out_weekday <= weekday;
        out_data.out_hour    <= hour;
        out_data.out_minute  <= minute;
        out_data.out_second  <= second;
        out_data.out_millis  <= millis;
      end
      default: ;
    endcase
  end

  assign sts.kind      = kind;
  assign sts.div_busy  = (cnt != 2'd0);
  assign sts.quot_zero = (quot == 17'd0);
  assign sts.n_zero    = (n == 16'd0);
  assign sts.t_zero    = (t_mon == 17'd0);

endmodule

@@ hw/rtl/ciau_ctrl.sv @@
module ciau_ctrl
  import ciau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          KIND_SEC:   state_next = S_SEC_D;
          KIND_MIN:   state_next = S_MIN_D;
          KIND_HOUR:  state_next = S_HOUR_D;
          KIND_DAY:   state_next = S_DKJ_D;
          KIND_MONTH: state_next = S_MON_D;
          KIND_YEAR: begin
            cmd.op     = OP_YEAR_ADD;
            state_next = S_LEAP_D;
          end
          default:    state_next = S_FINISH;
        endcase
      end
      S_SEC_D: begin
        cmd.op     = OP_DIV_SEC;
        state_next = S_SEC_W;
      end
      S_SEC_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_SEC;
          state_next = sts.quot_zero ? S_FINISH : S_MIN_D;
        end
      end
      S_MIN_D: begin
        cmd.op     = OP_DIV_MIN;
        state_next = S_MIN_W;
      end
      S_MIN_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_MIN;
          state_next = sts.quot_zero ? S_FINISH : S_HOUR_D;
        end
      end
      S_HOUR_D: begin
        cmd.op     = OP_DIV_HOUR;
        state_next = S_HOUR_W;
      end
      S_HOUR_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_HOUR;
          state_next = sts.quot_zero ? S_FINISH : S_DKJ_D;
        end
      end
      S_DKJ_D: begin
        cmd.op     = OP_DIV_YEAR;
        state_next = S_DKJ_W;
      end
      S_DKJ_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_KJ;
          state_next = S_DAY_LOOP;
        end
      end
      S_DAY_LOOP: begin
        if (sts.n_zero) begin
          state_next = S_ZEL_D;
        end else begin
          cmd.op = OP_DAY_STEP;
        end
      end
      S_MON_D: begin
        if (sts.t_zero) begin
          state_next = S_LEAP_D;
        end else begin
          cmd.op     = OP_DIV_MON;
          state_next = S_MON_W;
        end
      end
      S_MON_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_MON;
          state_next = S_LEAP_D;
        end
      end
      S_LEAP_D: begin
        cmd.op     = OP_DIV_YEAR;
        state_next = S_LEAP_W;
      end
      S_LEAP_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_KJ;
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.op     = OP_FIX;
        state_next = S_ZEL_D;
      end
      S_ZEL_D: begin
        cmd.op     = OP_DIV_ZEL;
        state_next = S_ZEL_W;
      end
      S_ZEL_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_ZKJ;
          state_next = S_F_D;
        end
      end
      S_F_D: begin
        cmd.op     = OP_DIV_F;
        state_next = S_F_W;
      end
      S_F_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_WR_WDAY;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/calendar_interval_adder_unit.sv @@
// Throughput: one transaction at a time; the next is taken the cycle after the result is
//   loaded into the output register, and waits only if that register is full.
// Reset: rst, synchronous, active high; returns to idle with no result pending.
module calendar_interval_adder_unit
  import ciau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Controller sequences the work; every calendar step happens in the datapath:
  //   - time adds: div by 60/60/24 on a shared reciprocal-multiply divider,
  //     the quotient carrying into the next field
  //   - day adds: one month per cycle, year%100 and year/100 kept in step
  //     so the leap test needs no divide inside the loop
  //   - month/year adds: div by 12 and/or div by 100 for the leap test,
  //     then the day fix-up
  //   - weekday: Zeller's congruence with two more divider passes (100, 7)
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ciau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // result register lives in the datapath; loaded as the controller retires a transaction
  ciau_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ hw/rtl/ciau_checker.sv @@
module ciau_checker
  import ciau_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_no_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without a transaction");

endmodule

bind calendar_interval_adder_unit ciau_checker u_chk (.*);

@@ dv/calendar_interval_adder_unit_tb.sv @@
module calendar_interval_adder_unit_tb;
  import ciau_pkg::*;

  // working copy of a date-time, wide enough that nothing wraps early
  typedef struct {
    int unsigned yr, mon, day, wday, hr, min, sec, ms;
  } stamp_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned HOLD_AT     = 60;    // after this many results
  localparam int unsigned DRAIN_AT    = 120;   // sender drains before this item
  localparam int unsigned QUIET_LO    = 150;   // no idling on either side in this
  localparam int unsigned QUIET_HI    = 200;   //   range of transactions

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;

  in_t  pending_q[$];      // stimulus not yet offered
  out_t date_exp_q[$];     // predicted results, oldest first
  int unsigned n_sent, n_rcvd, n_items, cyc, hold_cnt, n_errors;
  bit hold_done;

  calendar_interval_adder_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // ---------------------------------------------------------------------------
  // calendar arithmetic used for prediction
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap(y)) return 29;
    return lens[m];
  endfunction

  // Zeller, remapped to 1 = Monday .. 7 = Sunday; Jan/Feb count as months
  // 13/14 of the previous (16-bit wrapping) year
  function automatic int unsigned weekday_of(int unsigned y, int unsigned m,
                                             int unsigned d);
    int unsigned k, j, f;
    if (m < 3) begin
      m = m + 12;
      y = (y - 1) & 16'hFFFF;
    end
    k = y % 100;
    j = y / 100;
    f = d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j;
    return ((f % 7) + 5) % 7 + 1;
  endfunction

  // walk forward a month at a time; bad months have zero length
  function automatic void advance_days(ref stamp_t s, input int unsigned n);
    int unsigned len, left;
    while (n > 0) begin
      len  = month_days(s.yr, s.mon);
      left = (s.day <= len) ? len - s.day : 0;
      if (n <= left) begin
        s.day = s.day + n;
        n = 0;
      end else begin
        n = n - (left + 1);
        s.day = 1;
        s.mon++;
        if (s.mon > 12) begin
          s.mon = 1;
          s.yr = (s.yr + 1) & 16'hFFFF;
        end
      end
    end
    s.wday = weekday_of(s.yr, s.mon, s.day);
  endfunction

  function automatic void advance_hours(ref stamp_t s, input int unsigned n);
    int unsigned t;
    t = s.hr + n;
    s.hr = t % 24;
    if (t / 24 > 0) advance_days(s, t / 24);
  endfunction

  function automatic void advance_minutes(ref stamp_t s, input int unsigned n);
    int unsigned t;
    t = s.min + n;
    s.min = t % 60;
    if (t / 60 > 0) advance_hours(s, t / 60);
  endfunction

  function automatic out_t add_interval(in_t it);
    stamp_t s;
    out_t r;
    int unsigned t, len;
    s = '{it.in_year, it.in_month, it.in_day, it.in_weekday, it.in_hour,
          it.in_minute, it.in_second, it.in_millis};
    case (it.kind)
      KIND_SEC: begin
        t = s.sec + it.amount;
        s.sec = t % 60;
        if (t / 60 > 0) advance_minutes(s, t / 60);
      end
      KIND_MIN:  advance_minutes(s, it.amount);
      KIND_HOUR: advance_hours(s, it.amount);
      KIND_DAY:  advance_days(s, it.amount);
      KIND_MONTH: begin
        t = s.mon + it.amount;
        // month 0 plus nothing keeps month and year as they are
        if (t > 0) begin
          s.yr  = (s.yr + (t - 1) / 12) & 16'hFFFF;
          s.mon = (t - 1) % 12 + 1;
        end
        len = month_days(s.yr, s.mon);
        if (s.day > len) s.day = len;
        s.wday = weekday_of(s.yr, s.mon, s.day);
      end
      KIND_YEAR: begin
        s.yr = (s.yr + it.amount) & 16'hFFFF;
        if (s.mon == 2 && s.day == 29 && !is_leap(s.yr)) s.day = 28;
        s.wday = weekday_of(s.yr, s.mon, s.day);
      end
      default: ;  // unknown kinds copy the input
    endcase
    r.out_year    = s.yr[15:0];
    r.out_month   = s.mon[3:0];
    r.out_day     = s.day[4:0];
    r.out_weekday = s.wday[2:0];
    r.out_hour    = s.hr[4:0];
    r.out_minute  = s.min[5:0];
    r.out_second  = s.sec[5:0];
    r.out_millis  = s.ms[9:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  function automatic in_t make_item(logic [2:0] k, int unsigned amt, int unsigned y,
                                    int unsigned mo, int unsigned d, int unsigned wd,
                                    int unsigned h, int unsigned mi, int unsigned s,
                                    int unsigned ms);
    in_t it;
    it.kind = k;           it.amount = amt[15:0];  it.in_year = y[15:0];
    it.in_month = mo[3:0]; it.in_day = d[4:0];     it.in_weekday = wd[2:0];
    it.in_hour = h[4:0];   it.in_minute = mi[5:0]; it.in_second = s[5:0];
    it.in_millis = ms[9:0];
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int unsigned y, mo, pick;
    logic [2:0] k;
    int unsigned amt;
    k = 3'($urandom_range(0, 7));
    // amounts: mostly modest, sometimes full range; big day adds stay rare
    pick = $urandom_range(0, 19);
    if (k == KIND_DAY)
      amt = (pick == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 800);
    else
      amt = (pick < 6) ? $urandom_range(0, 65535) : $urandom_range(0, 500);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any field pattern at all
      it = in_t'({10'd0, $urandom, $urandom});
      it.kind = k;
      it.amount = amt[15:0];
    end else begin
      y  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(1890, 2110);
      mo = $urandom_range(1, 12);
      it = make_item(k, amt, y, mo, $urandom_range(1, month_days(y, mo)),
                     $urandom_range(0, 7), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(0, 999));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    // directed corners
    pending_q.push_back(make_item(3'd6, 16'hFFFF, 2024, 2, 29, 7, 23, 59, 59, 999));
    pending_q.push_back(make_item(3'd7, 0, 16'hFFFF, 15, 31, 0, 31, 63, 63, 1023));
    // no carry: out-of-range hour and minute left alone
    pending_q.push_back(make_item(KIND_SEC, 0, 2000, 1, 1, 3, 31, 63, 10, 5));
    pending_q.push_back(make_item(KIND_SEC, 16'hFFFF, 1999, 12, 31, 5, 23, 59, 59, 0));
    pending_q.push_back(make_item(KIND_SEC, 1, 2023, 12, 31, 7, 23, 59, 59, 500));
    pending_q.push_back(make_item(KIND_MIN, 16'hFFFF, 2100, 2, 28, 1, 22, 30, 0, 1));
    pending_q.push_back(make_item(KIND_HOUR, 16'hFFFF, 2400, 2, 28, 1, 0, 0, 0, 2));
    pending_q.push_back(make_item(KIND_HOUR, 1, 2024, 2, 28, 3, 23, 0, 0, 3));
    pending_q.push_back(make_item(KIND_DAY, 16'hFFFF, 16'hFFFF, 12, 31, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_DAY, 1, 1900, 2, 28, 0, 12, 0, 0, 0));
    pending_q.push_back(make_item(KIND_DAY, 0, 2000, 2, 29, 0, 12, 0, 0, 0));
    // day past the month's end, and invalid months in the day walk
    pending_q.push_back(make_item(KIND_DAY, 3, 2023, 2, 31, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_DAY, 5, 2023, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_DAY, 40, 2023, 13, 5, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_DAY, 2, 2023, 15, 31, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_MONTH, 0, 2023, 0, 0, 4, 1, 2, 3, 4));
    pending_q.push_back(make_item(KIND_MONTH, 0, 2023, 0, 15, 4, 1, 2, 3, 4));
    pending_q.push_back(make_item(KIND_MONTH, 1, 2023, 1, 31, 4, 1, 2, 3, 4));
    pending_q.push_back(make_item(KIND_MONTH, 16'hFFFF, 16'hFFFF, 12, 31, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_MONTH, 3, 2023, 14, 20, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_YEAR, 1, 2024, 2, 29, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_YEAR, 4, 2024, 2, 29, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_YEAR, 1, 16'hFFFF, 1, 1, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(KIND_YEAR, 16'hFFFF, 0, 3, 1, 0, 0, 0, 0, 0));
    repeat (250) pending_q.push_back(random_item());
    n_items = pending_q.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (n_sent == n_items && date_exp_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && date_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers pending items, predicts each one as its transaction lands
  // ---------------------------------------------------------------------------
  function automatic bit quiet_window();
    return (n_sent >= QUIET_LO && n_sent < QUIET_HI);
  endfunction

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    out_ready = 1'b0;
    n_sent = 0; n_rcvd = 0; cyc = 0; hold_cnt = 0; n_errors = 0; hold_done = 0;
  end

  always @(posedge clk) begin
    bit fire;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        date_exp_q.push_back(add_interval(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || fire) begin
        // one pause: let everything drain before this transaction goes out
        if (pending_q.size() == 0 ||
            (n_sent + fire == DRAIN_AT && (date_exp_q.size() != 0 || fire)) ||
            (!quiet_window() && $urandom_range(0, 99) < 18)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_rcvd <= n_rcvd + 1;
        if (date_exp_q.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          n_errors++;
        end else begin
          want = date_exp_q.pop_front();
          if (out_data.out_year !== want.out_year) begin
            $error("out_year exp %0d got %0d", want.out_year, out_data.out_year);
            n_errors++;
          end
          if (out_data.out_month !== want.out_month) begin
            $error("out_month exp %0d got %0d", want.out_month, out_data.out_month);
            n_errors++;
          end
          if (out_data.out_day !== want.out_day) begin
            $error("out_day exp %0d got %0d", want.out_day, out_data.out_day);
            n_errors++;
          end
          if (out_data.out_weekday !== want.out_weekday) begin
            $error("out_weekday exp %0d got %0d", want.out_weekday,
                   out_data.out_weekday);
            n_errors++;
          end
          if (out_data.out_hour !== want.out_hour) begin
            $error("out_hour exp %0d got %0d", want.out_hour, out_data.out_hour);
            n_errors++;
          end
          if (out_data.out_minute !== want.out_minute) begin
            $error("out_minute exp %0d got %0d", want.out_minute, out_data.out_minute);
            n_errors++;
          end
          if (out_data.out_second !== want.out_second) begin
            $error("out_second exp %0d got %0d", want.out_second, out_data.out_second);
            n_errors++;
          end
          if (out_data.out_millis !== want.out_millis) begin
            $error("out_millis exp %0d got %0d", want.out_millis, out_data.out_millis);
            n_errors++;
          end
        end
      end
      // long hold-off once, so the block backs up and stalls its input
      if (!hold_done && n_rcvd >= HOLD_AT) begin
        out_ready <= 1'b0;
        hold_cnt  <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
      end else if (quiet_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 18);
      end
    end
  end

endmodule

@@ calendar_interval_adder_unit.f @@
hw/rtl/ciau_pkg.sv
hw/rtl/ciau_datapath.sv
hw/rtl/ciau_ctrl.sv
hw/rtl/calendar_interval_adder_unit.sv
hw/rtl/ciau_checker.sv
dv/calendar_interval_adder_unit_tb.sv
